// ===== sv/csm_pkg.sv =====
package csm_pkg;

    localparam int MAX_ROWS_DEF       = 8;
    localparam int MAX_COLS_DEF       = 8;
    localparam int EXP_TABLE_BITS_DEF = 10;
    localparam int SCORE_W            = 16;
    localparam int EXP_W              = 17;
    localparam int SUM_W              = 20;
    localparam int PROB_W             = 16;
    localparam int DIM_W              = 4;
    localparam int IDX_W              = 3;
    localparam int LOG2E_Q16          = 94548;
    localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [4:0] {
        ST_LOAD = 5'b00001,
        ST_EXP  = 5'b00010,
        ST_FIX  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    // one request for the divider: (e << 16) / sum
    typedef struct packed {
        logic             start;
        logic [EXP_W-1:0] num;
        logic [SUM_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROB_W-1:0] quo;
    } div_rsp_t;

    // floor(x / d) for 0 <= x < 2^41, shift and subtract
    function automatic longint floor_div(input longint x, input longint d);
        longint q;
        longint rem;
        q   = 0;
        rem = 0;
        for (int b = 40; b >= 0; b--)
        begin
            rem = (rem << 1) | ((x >>> b) & 64'sd1);
            q   = q << 1;
            if (rem >= d)
            begin
                rem = rem - d;
                q   = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // round(65536 * 2^(-k/2^bits)) computed with a Q30 series at elaboration
    function automatic logic [EXP_W-1:0] exp_entry(input int k, input int bits);
        longint acc;
        longint term;
        longint r;
        acc  = 64'sd1 << 30;
        term = 64'sd1 << 30;
        r    = (longint'(k) * 64'sd744261118) >>> bits;
        for (int n = 1; n <= 24; n++)
        begin
            if (term != 0)
            begin
                term = floor_div((term * r) >>> 30, longint'(n));
                if ((n & 1) == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
        end
        if (acc < 0)
            acc = 0;
        return EXP_W'((acc + 8192) >>> 14);
    endfunction

endpackage

// ===== sv/csm_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating at all ones.
module csm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  csm_pkg::div_req_t req,
    output csm_pkg::div_rsp_t rsp
);
    import csm_pkg::*;

    localparam int NUM_W = EXP_W + 16;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [SUM_W:0]   rem_reg, rem_next;
    logic [SUM_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SUM_W:0]   trial;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[SUM_W-1:0], num_reg[NUM_W-1]};
        if (req.start)
        begin
            num_next  = {req.num, 16'd0};
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = (|num_reg[NUM_W-1:PROB_W]) ? {PROB_W{1'b1}} : num_reg[PROB_W-1:0];

endmodule

// ===== sv/columnwise_softmax.sv =====
// Column-wise softmax over one rows x cols matrix of signed Q8.8 scores taken
// in row-major order, one per cycle while loading. After the last score the
// block takes no input: an exp pass (per element: score read, table read,
// then shift and column accumulate), a state for the tiny-sum guard, and then
// a normalize pass over the stored matrix; each result needs a read, a start,
// one divide in a bit-serial divider over a 33-bit dividend, the done handoff
// and the output load, and results leave row-major through an output register
// with row, column and last marks; a matrix takes longer when the result side
// stalls. Loading of the next matrix may start once the last result sits in
// the output register.
// Writing a dimension register drops any partial matrix.
module columnwise_softmax #(
    parameter int MAX_ROWS       = csm_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS       = csm_pkg::MAX_COLS_DEF,
    parameter int EXP_TABLE_BITS = csm_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [csm_pkg::DIM_W-1:0] cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,   // score
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,   // probability, row_index, col_index, pad
    output logic                      m_tlast    // last_of_matrix
);
    import csm_pkg::*;

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int TSIZE   = 1 << EXP_TABLE_BITS;
    localparam int GAP_W   = 17;
    localparam int Y_W     = GAP_W + 17 - 8;

    logic [SCORE_W-1:0] score_mem [DEPTH];
    logic [EXP_W-1:0]   exp_mem   [DEPTH];
    logic [EXP_W-1:0]   exp_rom   [TSIZE];
    logic [SUM_W-1:0]   sum_reg   [MAX_COLS];

    logic [DIM_W-1:0]   rows_reg, cols_reg;
    logic [CNT_W-1:0]   rows_c, cols_c, total;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic signed [SCORE_W-1:0] max_reg;
    state_t             st_reg;
    logic [1:0]         sub_reg;
    logic [SCORE_W-1:0] score_rd;
    logic [EXP_W-1:0]   exp_rd;
    logic [EXP_W-1:0]   tab_rd;
    logic               in_acc, out_acc;
    logic               load_out;
    logic               last_elem;
    logic [ADDR_W-1:0]  rd_addr;

    logic [GAP_W-1:0]   gap;
    logic [Y_W-1:0]     yq;
    logic [Y_W-17:0]    ip, ip_reg;
    logic [EXP_W-1:0]   eval;
    logic [SUM_W:0]     sum_add;

    div_req_t           dreq;
    div_rsp_t           drsp;

    logic               ov_reg;
    logic [PROB_W-1:0]  op_reg;
    logic [IDX_W-1:0]   orow_reg, ocol_reg;
    logic               olast_reg;

    // exponent table, 2^(-k/2^bits) in unsigned Q1.16
    initial
        for (int i = 0; i < TSIZE; i++)
            exp_rom[i] = exp_entry(i, EXP_TABLE_BITS);

    always_comb
    begin
        rows_c = (rows_reg == '0) ? CNT_W'(1) :
                 (CNT_W'(rows_reg) > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(rows_reg);
        cols_c = (cols_reg == '0) ? CNT_W'(1) :
                 (CNT_W'(cols_reg) > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : CNT_W'(cols_reg);
    end

    assign total = CNT_W'(rows_c * cols_c);

    assign s_tready  = (st_reg == ST_LOAD);
    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = ov_reg && m_tready;
    assign load_out  = (st_reg == ST_OUT) && !cfg_we && (!ov_reg || out_acc);
    assign last_elem = (cnt_reg == total - 1'b1);

    assign gap  = GAP_W'($signed({max_reg[SCORE_W-1], max_reg})
                  - $signed({score_rd[SCORE_W-1], score_rd}));
    assign yq   = Y_W'((34'(gap) * 34'(LOG2E_Q16)) >> 8);
    assign ip   = yq[Y_W-1:16];
    assign eval = (ip_reg >= (Y_W-16)'(17)) ? '0 : (tab_rd >> ip_reg);
    assign sum_add = {1'b0, sum_reg[col_reg]} + (SUM_W+1)'(eval);

    assign rd_addr = addr_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
            score_mem[cnt_reg[ADDR_W-1:0]] <= s_tdata;
        score_rd <= score_mem[rd_addr];
        tab_rd   <= exp_rom[yq[15:16-EXP_TABLE_BITS]];
        ip_reg   <= ip;
        if (st_reg == ST_EXP && sub_reg == 2'd2)
            exp_mem[addr_reg] <= eval;
        exp_rd <= exp_mem[rd_addr];
    end

    assign dreq.start = (st_reg == ST_DIV) && (sub_reg == 2'd1);
    assign dreq.num   = exp_rd;
    assign dreq.den   = sum_reg[col_reg];

    csm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= DIM_W'(8);
            cols_reg  <= DIM_W'(8);
            st_reg    <= ST_LOAD;
            sub_reg   <= '0;
            cnt_reg   <= '0;
            addr_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            max_reg   <= 16'sh8000;
            ov_reg    <= 1'b0;
            for (int i = 0; i < MAX_COLS; i++)
                sum_reg[i] <= '0;
        end
        else
        begin
            if (load_out)
                ov_reg <= 1'b1;
            else if (out_acc)
                ov_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == REG_ROWS)
                    rows_reg <= cfg_data;
                else
                    cols_reg <= cfg_data;
                cnt_reg <= '0;
                max_reg <= 16'sh8000;
                st_reg  <= ST_LOAD;
            end
            else
            begin
                unique case (st_reg)
                    ST_LOAD:
                    begin
                        if (in_acc)
                        begin
                            if ($signed(s_tdata) > max_reg)
                                max_reg <= $signed(s_tdata);
                            if (last_elem)
                            begin
                                st_reg   <= ST_EXP;
                                sub_reg  <= '0;
                                addr_reg <= '0;
                                col_reg  <= '0;
                                for (int i = 0; i < MAX_COLS; i++)
                                    sum_reg[i] <= '0;
                            end
                            else
                                cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    ST_EXP:
                    begin
                        // sub 0: score read; sub 1: table read; sub 2: shift and accumulate
                        if (sub_reg == 2'd0)
                            sub_reg <= 2'd1;
                        else if (sub_reg == 2'd1)
                            sub_reg <= 2'd2;
                        else
                        begin
                            sub_reg <= 2'd0;
                            sum_reg[col_reg] <= sum_add[SUM_W] ? SUM_LIMIT : sum_add[SUM_W-1:0];
                            if (CNT_W'(addr_reg) == total - 1'b1)
                            begin
                                st_reg   <= ST_FIX;
                                addr_reg <= '0;
                                col_reg  <= '0;
                                row_reg  <= '0;
                            end
                            else
                            begin
                                addr_reg <= addr_reg + 1'b1;
                                if (CNT_W'(col_reg) == cols_c - 1'b1)
                                    col_reg <= '0;
                                else
                                    col_reg <= col_reg + 1'b1;
                            end
                        end
                    end
                    ST_FIX:
                    begin
                        // tiny-sum guard
                        for (int i = 0; i < MAX_COLS; i++)
                            if (sum_reg[i] == '0)
                                sum_reg[i] <= SUM_W'(1);
                        st_reg  <= ST_DIV;
                        sub_reg <= '0;
                    end
                    ST_DIV:
                    begin
                        if (sub_reg == 2'd0)
                            sub_reg <= 2'd1;
                        else if (sub_reg == 2'd1)
                            sub_reg <= 2'd2;
                        else if (drsp.done)
                        begin
                            st_reg <= ST_OUT;
                        end
                    end
                    ST_OUT:
                    begin
                        if (!ov_reg || out_acc)
                        begin
                            sub_reg   <= '0;
                            if (CNT_W'(addr_reg) == total - 1'b1)
                            begin
                                st_reg  <= ST_LOAD;
                                cnt_reg <= '0;
                                max_reg <= 16'sh8000;
                            end
                            else
                            begin
                                st_reg   <= ST_DIV;
                                addr_reg <= addr_reg + 1'b1;
                                if (CNT_W'(col_reg) == cols_c - 1'b1)
                                begin
                                    col_reg <= '0;
                                    row_reg <= row_reg + 1'b1;
                                end
                                else
                                    col_reg <= col_reg + 1'b1;
                            end
                        end
                    end
                    default:
                        st_reg <= ST_LOAD;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            op_reg    <= drsp.quo;
            orow_reg  <= IDX_W'(row_reg);
            ocol_reg  <= IDX_W'(col_reg);
            olast_reg <= (CNT_W'(addr_reg) == total - 1'b1);
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, ocol_reg, orow_reg, op_reg};
    assign m_tlast  = olast_reg;

endmodule

// ===== sim/softmax_checker.sv =====
module softmax_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [csm_pkg::DIM_W-1:0] cfg_data,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [15:0]               s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [23:0]               m_tdata,
    input  logic                      m_tlast,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import csm_pkg::*;

    localparam int TBL_BITS = EXP_TABLE_BITS_DEF;

    typedef struct packed {
        logic [PROB_W-1:0] prob;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last;
    } prob_t;

    prob_t              prob_queue[$];
    logic [EXP_W-1:0]   pow_table[1 << TBL_BITS];
    logic signed [15:0] scores[64];
    int                 n_loaded;
    int                 peak;
    logic [DIM_W-1:0]   rows_reg;
    logic [DIM_W-1:0]   cols_reg;

    // round(65536 * 2^(-k/2^B)) by the Q30 series
    function automatic logic [EXP_W-1:0] pow2_neg(input int k);
        longint acc;
        longint term;
        longint r;
        acc  = 64'sd1 << 30;
        term = 64'sd1 << 30;
        r    = (longint'(k) * 64'sd744261118) >>> TBL_BITS;
        for (int n = 1; n <= 24; n++)
        begin
            if (term != 0)
            begin
                term = ((term * r) >>> 30) / n;
                acc  = (n % 2 == 1) ? acc - term : acc + term;
            end
        end
        if (acc < 0)
            acc = 0;
        return EXP_W'((acc + 8192) >>> 14);
    endfunction

    function automatic int clip_dim(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > 8)
            return 8;
        return int'(v);
    endfunction

    function automatic logic [EXP_W-1:0] exp_gap(input longint d);
        longint y;
        longint ip;
        int     idx;
        y   = (d * LOG2E_Q16) >>> 8;
        ip  = y >>> 16;
        idx = int'((y & 16'hFFFF) >> (16 - TBL_BITS));
        if (ip >= 17)
            return '0;
        return pow_table[idx] >> ip;
    endfunction

    task automatic predict_matrix(input int rows, input int cols);
        logic [EXP_W-1:0] ex[64];
        longint           sums[8];
        longint           p;
        prob_t            r;
        for (int c = 0; c < 8; c++)
            sums[c] = 0;
        for (int e = 0; e < rows * cols; e++)
        begin
            ex[e] = exp_gap(longint'(peak) - longint'(scores[e]));
            sums[e % cols] += ex[e];
            if (sums[e % cols] > 1048575)
                sums[e % cols] = 1048575;
        end
        for (int c = 0; c < cols; c++)
            if (sums[c] == 0)
                sums[c] = 1;
        for (int e = 0; e < rows * cols; e++)
        begin
            p = (longint'(ex[e]) << 16) / sums[e % cols];
            r.prob = (p > 65535) ? 16'hFFFF : PROB_W'(p);
            r.row  = IDX_W'(e / cols);
            r.col  = IDX_W'(e % cols);
            r.last = (e + 1 == rows * cols);
            prob_queue.insert(prob_queue.size(), r);
        end
    endtask

    initial
        for (int k = 0; k < (1 << TBL_BITS); k++)
            pow_table[k] = pow2_neg(k);

    assign pending = prob_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        prob_t want;
        int    total;
        if (!rst_n)
        begin
            fail_count = 0;
            n_loaded   = 0;
            peak       = -32768;
            rows_reg   = 8;
            cols_reg   = 8;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ROWS)
                    rows_reg = cfg_data;
                else
                    cols_reg = cfg_data;
                n_loaded = 0;
                peak     = -32768;
            end
            if (s_tvalid && s_tready)
            begin
                total = clip_dim(rows_reg) * clip_dim(cols_reg);
                scores[n_loaded] = s_tdata;
                if (int'($signed(s_tdata)) > peak)
                    peak = int'($signed(s_tdata));
                n_loaded++;
                if (n_loaded >= total)
                begin
                    predict_matrix(clip_dim(rows_reg), clip_dim(cols_reg));
                    n_loaded = 0;
                    peak     = -32768;
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (prob_queue.size() == 0)
                begin
                    $error("unexpected result %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = prob_queue.pop_front();
                    if (m_tdata[15:0] !== want.prob)
                    begin
                        $error("probability exp %0d got %0d", want.prob, m_tdata[15:0]);
                        fail_count++;
                    end
                    if (m_tdata[18:16] !== want.row)
                    begin
                        $error("row_index exp %0d got %0d", want.row, m_tdata[18:16]);
                        fail_count++;
                    end
                    if (m_tdata[21:19] !== want.col)
                    begin
                        $error("col_index exp %0d got %0d", want.col, m_tdata[21:19]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_of_matrix exp %0d got %0d", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/columnwise_softmax_tb.sv =====
module columnwise_softmax_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csm_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [DIM_W-1:0] cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [15:0]      s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [23:0]      m_tdata;
    logic             m_tlast;
    int               fail_count;
    int               pending;
    int               n_sent;
    bit               calm;

    columnwise_softmax uut (.*);
    softmax_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // result side stalls
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(99) >= 17);

    // leaves s_tvalid high; the next call or the caller takes it down
    task automatic send_score(input logic [15:0] v);
        while (!calm && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c);
        s_tvalid  <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROWS;
        cfg_data  <= r;
        @(posedge clk);
        cfg_index <= REG_COLS;
        cfg_data  <= c;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_score(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(255)) - 16'd128;
            default: return 16'($urandom_range(3)) * 16'h1000;
        endcase
    endfunction

    initial
    begin
        logic [DIM_W-1:0] r;
        logic [DIM_W-1:0] c;
        int               mode;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_ROWS;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        calm      = 1'b0;
        n_sent    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, saturation, wide/zero dims
        set_dims(4'd2, 4'd2);
        send_score(16'h7FFF); send_score(16'h8000);
        send_score(16'h8000); send_score(16'h7FFF);
        drain();
        set_dims(4'd0, 4'd15);   // 1 x 8
        for (int i = 0; i < 8; i++)
            send_score(i[0] ? 16'hFFFF : 16'h0000);
        drain();
        set_dims(4'd15, 4'd0);   // 8 x 1
        for (int i = 0; i < 8; i++)
            send_score(16'h5555 ^ {16{i[0]}});
        drain();
        // partial matrix dropped by a write
        set_dims(4'd3, 4'd3);
        send_score(16'h1234);
        send_score(16'h4321);
        set_dims(4'd1, 4'd1);
        send_score(16'h8000);
        drain();

        calm = 1'b1;
        set_dims(4'd8, 4'd8);
        for (int i = 0; i < 64; i++)
            send_score(rand_score(i % 3));
        drain();
        calm = 1'b0;

        while (n_sent < 410)
        begin
            r = 4'($urandom_range(4));
            c = 4'($urandom_range(4));
            if ($urandom_range(9) == 0)
            begin
                r = 4'($urandom_range(15));
                c = 4'($urandom_range(15));
            end
            set_dims(r, c);
            mode = $urandom_range(2);
            repeat ($urandom_range(1, 3))
            begin
                for (int i = 0; i < ((r == 0) ? 1 : (r > 8 ? 8 : r)) *
                                    ((c == 0) ? 1 : (c > 8 ? 8 : c)); i++)
                    send_score(rand_score(mode));
            end
            drain();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== columnwise_softmax.f =====
sv/csm_pkg.sv
sv/csm_div.sv
sv/columnwise_softmax.sv
sim/softmax_checker.sv
sim/columnwise_softmax_tb.sv
